// File: rtl/sfiw_pkg.sv
package sfiw_pkg;

    // Default geometry of the flash part.
    localparam int PAGE_BYTES_DEF   = 256;
    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int ADDR_BITS_DEF    = 24;

    // Fixed field widths.
    localparam int OFS_W   = 24;
    localparam int SIZE_W  = 16;
    localparam int VALID_W = 9;

    // Register reset values.
    localparam logic [15:0] MIN_SIZE_RST   = 16'd16;
    localparam logic [23:0] MAX_SIZE_RST   = 24'd1048576;
    localparam logic [23:0] FLASH_BASE_RST = 24'd0;
    localparam logic [15:0] IDLE_LIMIT_RST = 16'd3000;

    localparam logic [7:0]  PAD_BYTE = 8'hFF;
    localparam logic [15:0] IDLE_MAX = 16'hFFFF;

    // Register indexes.
    typedef enum logic [1:0] {
        REG_MIN_SIZE   = 2'd0,
        REG_MAX_SIZE   = 2'd1,
        REG_FLASH_BASE = 2'd2,
        REG_IDLE_LIMIT = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_BEGIN    = 2'd0,
        MODE_CHUNK    = 2'd1,
        MODE_FINALIZE = 2'd2,
        MODE_TICK     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_ERASE   = 2'd1,
        KIND_STAGED  = 2'd2,
        KIND_PROGRAM = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_INACTIVE     = 3'd1,
        ST_OUT_OF_ORDER = 3'd2,
        ST_OVERFLOW     = 3'd3,
        ST_BAD_SIZE     = 3'd4,
        ST_IDLE_ABORT   = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] size_or_offset;
        logic [7:0]  chunk_length;
        logic        chunk_start;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [23:0] flash_address;
        logic [7:0]  byte_value;
        logic [8:0]  valid_bytes;
        logic [23:0] accepted_count;
        logic        transfer_active;
        logic        last;
    } result_t;

endpackage

// File: rtl/sequential_flash_image_writer.sv
// Channel   Direction  Handshake                         Payload
// item      in         item_valid / item_ready           sfiw_pkg::item_t
// result    out        result_valid / result_ready       sfiw_pkg::result_t
// config    in         APB psel/penable/pwrite, pready=1 4 registers at 4*index
//
// An accepted item is decoded combinationally and its zero to four results are
// loaded into a four-entry result buffer, which drains one result a cycle
// while result_ready is high. A tick with no abort loads no results. The
// buffer drain sets the rate.
// item_ready is high while the buffer is empty or on its last result being
// taken. Reset clears all transfer state and returns the registers to their
// defaults; there is no clearing pass.
module sequential_flash_image_writer #(
    parameter int PAGE_BYTES   = sfiw_pkg::PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = sfiw_pkg::SECTOR_BYTES_DEF,
    parameter int ADDRESS_BITS = sfiw_pkg::ADDR_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  sfiw_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output sfiw_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import sfiw_pkg::*;

    // Wide enough for flash base plus a full image plus one page and sector.
    localparam int EW  = OFS_W + 2;
    localparam int PFW = $clog2(PAGE_BYTES + 1);
    localparam logic [OFS_W-1:0] ADDR_MASK = (ADDRESS_BITS >= OFS_W) ?
        {OFS_W{1'b1}} : OFS_W'((64'd1 << ADDRESS_BITS) - 64'd1);

    // Configuration registers.
    logic [15:0] min_size_reg;
    logic [23:0] max_size_reg;
    logic [23:0] flash_base_reg;
    logic [15:0] idle_limit_reg;

    // Transfer state.
    logic             active_reg, active_next;
    logic             chunk_ok_reg, chunk_ok_next;
    logic [23:0]      image_size_reg, image_size_next;
    logic [23:0]      next_offset_reg, next_offset_next;
    logic [EW-1:0]    erased_end_reg, erased_end_next;
    logic [PFW-1:0]   page_fill_reg, page_fill_next;
    logic [15:0]      idle_ticks_reg, idle_ticks_next;

    // Result buffer.
    result_t          buf_reg [4];
    result_t          res [4];
    logic [2:0]       cnt_reg;
    logic [2:0]       pos_reg;
    logic [2:0]       res_cnt;

    logic cfg_write;
    logic item_fire;
    logic result_fire;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_size_reg   <= MIN_SIZE_RST;
            max_size_reg   <= MAX_SIZE_RST;
            flash_base_reg <= FLASH_BASE_RST;
            idle_limit_reg <= IDLE_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_MIN_SIZE:   min_size_reg   <= pwdata[15:0];
                REG_MAX_SIZE:   max_size_reg   <= pwdata[23:0];
                REG_FLASH_BASE: flash_base_reg <= pwdata[23:0];
                REG_IDLE_LIMIT: idle_limit_reg <= pwdata[15:0];
                default:        min_size_reg   <= min_size_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_MIN_SIZE:   prdata = {16'd0, min_size_reg};
            REG_MAX_SIZE:   prdata = {8'd0, max_size_reg};
            REG_FLASH_BASE: prdata = {8'd0, flash_base_reg};
            REG_IDLE_LIMIT: prdata = {16'd0, idle_limit_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // Handshakes.
    assign result_valid = (pos_reg < cnt_reg);
    assign result_fire  = result_valid && result_ready;
    assign item_ready   = !result_valid || (result_ready && (pos_reg == cnt_reg - 3'd1));
    assign item_fire    = item_valid && item_ready;

    // Builds one result entry with the shared fields left clear.
    function automatic result_t make_res(input kind_t k, input status_t s,
                                         input logic [EW-1:0] a,
                                         input logic [7:0] b,
                                         input logic [8:0] v);
        result_t r;
        r                 = '0;
        r.kind            = k;
        r.status          = s;
        r.flash_address   = a[OFS_W-1:0] & ADDR_MASK;
        r.byte_value      = b;
        r.valid_bytes     = v;
        return r;
    endfunction

    // Decode of one item into its state update and result list.
    logic [EW-1:0]  page_start;
    logic [EW-1:0]  stage_addr;
    logic           need_erase;
    logic [PFW-1:0] fill_inc;
    logic [15:0]    idle_inc;
    logic           chunk_over;
    logic           pre_status, post_status, do_stage, do_partial;
    status_t        st_code;

    always_comb
    begin
        page_start = {2'b00, flash_base_reg} + {2'b00, next_offset_reg}
                     - EW'(page_fill_reg);
        stage_addr = {2'b00, flash_base_reg} + {2'b00, next_offset_reg};
        need_erase = erased_end_reg < (page_start + EW'(PAGE_BYTES));
        fill_inc   = page_fill_reg + PFW'(1);
        idle_inc   = (idle_ticks_reg == IDLE_MAX) ? idle_ticks_reg
                                                  : idle_ticks_reg + 16'd1;
        chunk_over = ({1'b0, next_offset_reg} + 25'(item.chunk_length))
                     > {1'b0, image_size_reg};

        active_next      = active_reg;
        chunk_ok_next    = chunk_ok_reg;
        image_size_next  = image_size_reg;
        next_offset_next = next_offset_reg;
        erased_end_next  = erased_end_reg;
        page_fill_next   = page_fill_reg;
        idle_ticks_next  = idle_ticks_reg;

        pre_status  = 1'b0;
        post_status = 1'b0;
        do_stage    = 1'b0;
        do_partial  = 1'b0;
        st_code     = ST_OK;

        case (mode_t'(item.mode))
            MODE_BEGIN:
            begin
                pre_status = 1'b1;
                if ({8'd0, item.size_or_offset} < {16'd0, min_size_reg} ||
                    item.size_or_offset > max_size_reg)
                begin
                    st_code = ST_BAD_SIZE;
                end
                else
                begin
                    active_next      = 1'b1;
                    image_size_next  = item.size_or_offset;
                    next_offset_next = '0;
                    page_fill_next   = '0;
                    erased_end_next  = {2'b00, flash_base_reg};
                    idle_ticks_next  = '0;
                    chunk_ok_next    = 1'b0;
                end
            end
            MODE_CHUNK:
            begin
                if (item.chunk_start)
                begin
                    pre_status = 1'b1;
                    if (!active_reg)
                        st_code = ST_INACTIVE;
                    else if (item.size_or_offset != next_offset_reg)
                        st_code = ST_OUT_OF_ORDER;
                    else if (chunk_over)
                        st_code = ST_OVERFLOW;
                    else
                        st_code = ST_OK;
                    chunk_ok_next = (st_code == ST_OK);
                    if (st_code == ST_OK)
                    begin
                        idle_ticks_next = '0;
                        do_stage = (item.chunk_length != 8'd0);
                    end
                end
                else if (!active_reg)
                begin
                    pre_status = 1'b1;
                    st_code    = ST_INACTIVE;
                end
                else if (!chunk_ok_reg)
                begin
                    pre_status = 1'b1;
                    st_code    = ST_OUT_OF_ORDER;
                end
                else if (next_offset_reg >= image_size_reg)
                begin
                    pre_status = 1'b1;
                    st_code    = ST_OVERFLOW;
                end
                else
                begin
                    do_stage = 1'b1;
                end
            end
            MODE_FINALIZE:
            begin
                if (!active_reg)
                begin
                    pre_status = 1'b1;
                    st_code    = ST_INACTIVE;
                end
                else
                begin
                    do_partial    = (page_fill_reg != '0);
                    post_status   = 1'b1;
                    active_next   = 1'b0;
                    chunk_ok_next = 1'b0;
                end
            end
            default:
            begin
                if (active_reg)
                begin
                    idle_ticks_next = idle_inc;
                    if (idle_inc > idle_limit_reg)
                    begin
                        active_next    = 1'b0;
                        chunk_ok_next  = 1'b0;
                        page_fill_next = '0;
                        pre_status     = 1'b1;
                        st_code        = ST_IDLE_ABORT;
                    end
                end
            end
        endcase

        // Fill the result list in emission order.
        res[0]  = '0;
        res[1]  = '0;
        res[2]  = '0;
        res[3]  = '0;
        res_cnt = 3'd0;
        if (pre_status)
        begin
            res[res_cnt[1:0]] = make_res(KIND_STATUS, st_code, '0, 8'd0, 9'd0);
            res_cnt = res_cnt + 3'd1;
        end
        if (do_stage)
        begin
            res[res_cnt[1:0]] = make_res(KIND_STAGED, ST_OK, stage_addr,
                                         item.data_byte, 9'd0);
            res_cnt          = res_cnt + 3'd1;
            next_offset_next = next_offset_reg + 24'd1;
            page_fill_next   = fill_inc;
            idle_ticks_next  = '0;
        end
        if ((do_stage && fill_inc >= PFW'(PAGE_BYTES)) || do_partial)
        begin
            if (need_erase)
            begin
                res[res_cnt[1:0]] = make_res(KIND_ERASE, ST_OK, erased_end_reg,
                                             8'd0, 9'd0);
                res_cnt         = res_cnt + 3'd1;
                erased_end_next = erased_end_reg + EW'(SECTOR_BYTES);
            end
            res[res_cnt[1:0]] = make_res(KIND_PROGRAM, ST_OK, page_start, 8'd0,
                                         do_partial ? 9'(page_fill_reg)
                                                    : 9'(PAGE_BYTES));
            res_cnt        = res_cnt + 3'd1;
            page_fill_next = '0;
        end
        if (post_status)
        begin
            res[res_cnt[1:0]] = make_res(KIND_STATUS, ST_OK, '0, 8'd0, 9'd0);
            res_cnt = res_cnt + 3'd1;
        end

        // Shared fields reflect the state after the whole item.
        for (int i = 0; i < 4; i++)
        begin
            res[i].accepted_count  = next_offset_next;
            res[i].transfer_active = active_next;
        end
    end

    // State and result buffer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            chunk_ok_reg    <= 1'b0;
            image_size_reg  <= '0;
            next_offset_reg <= '0;
            erased_end_reg  <= '0;
            page_fill_reg   <= '0;
            idle_ticks_reg  <= '0;
            cnt_reg         <= 3'd0;
            pos_reg         <= 3'd0;
        end
        else if (item_fire)
        begin
            active_reg      <= active_next;
            chunk_ok_reg    <= chunk_ok_next;
            image_size_reg  <= image_size_next;
            next_offset_reg <= next_offset_next;
            erased_end_reg  <= erased_end_next;
            page_fill_reg   <= page_fill_next;
            idle_ticks_reg  <= idle_ticks_next;
            cnt_reg         <= res_cnt;
            pos_reg         <= 3'd0;
        end
        else if (result_fire)
        begin
            pos_reg <= pos_reg + 3'd1;
        end
    end

    // Buffer payload.
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            for (int i = 0; i < 4; i++)
                buf_reg[i] <= res[i];
        end
    end

    // Present the current entry, marking the final one of the item.
    always_comb
    begin
        result      = buf_reg[pos_reg[1:0]];
        result.last = (pos_reg == cnt_reg - 3'd1);
    end

endmodule
